// ===== rtl/core/c2s_pkg.sv =====
// ----------------------------------------------------------------------------
// c2s_pkg
// Types, constants and the arctangent step table for the cartesian to
// spherical conversion core.
// ----------------------------------------------------------------------------
package c2s_pkg;

	localparam int COORD_W       = 32;
	localparam int ANGLE_W       = 32;
	localparam int RADIUS_W      = 32;
	localparam int VEC_W         = 64;
	localparam int GUARD_BITS    = 24;
	localparam int ROOT_STEPS    = 32;
	localparam int ANGLE_ENTRIES = 31;

	localparam logic signed [31:0] GAIN_Q30 = 32'sd1768195363;

	localparam logic [ANGLE_W-1:0] ANGLE_ZERO        = 32'h0000_0000;
	localparam logic [ANGLE_W-1:0] ANGLE_PI          = 32'h8000_0000;
	localparam logic [ANGLE_W-1:0] ANGLE_HALF_PI     = 32'h4000_0000;
	localparam logic [ANGLE_W-1:0] ANGLE_NEG_HALF_PI = 32'hC000_0000;

	localparam logic [ANGLE_W-1:0] ATAN_TABLE [ANGLE_ENTRIES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
		32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
		32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
		32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
		32'd1
	};

	typedef struct packed {
		logic x_neg;
		logic x_zero;
		logic y_zero;
		logic y_pos;
		logic z_pos;
		logic z_neg;
	} c2s_flags_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] cx;
		logic signed [VEC_W-1:0] cy;
		logic signed [VEC_W-1:0] lz;
		logic [ANGLE_W-1:0]      lon_acc;
		logic [ANGLE_W-1:0]      lat_acc;
		logic [VEC_W-1:0]        rem;
		logic [VEC_W-1:0]        root;
		c2s_flags_t              flags;
	} c2s_work_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] longitude;
		logic signed [ANGLE_W-1:0] latitude;
		logic [RADIUS_W-1:0]       radius;
	} c2s_result_t;

	function automatic logic [ANGLE_W-1:0] atan_angle(input int idx);
		logic [ANGLE_W-1:0] step;
		step = ANGLE_ZERO;
		if (idx >= 0 && idx < ANGLE_ENTRIES) begin
			step = ATAN_TABLE[idx[4:0]];
		end
		return step;
	endfunction

endpackage

// ===== rtl/core/c2s_in_if.sv =====
// ----------------------------------------------------------------------------
// c2s_in_if
// Input channel: one cartesian point per word.
// ----------------------------------------------------------------------------
interface c2s_in_if
	import c2s_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] x_coord;
	logic signed [COORD_W-1:0] y_coord;
	logic signed [COORD_W-1:0] z_coord;

	modport source (output valid, output x_coord, output y_coord, output z_coord,
		input ready);
	modport sink (input valid, input x_coord, input y_coord, input z_coord,
		output ready);
endinterface

// ===== rtl/core/c2s_out_if.sv =====
// ----------------------------------------------------------------------------
// c2s_out_if
// Output channel: longitude, latitude and radius per word.
// ----------------------------------------------------------------------------
interface c2s_out_if
	import c2s_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [ANGLE_W-1:0] longitude;
	logic signed [ANGLE_W-1:0] latitude;
	logic [RADIUS_W-1:0]       radius;

	modport source (output valid, output longitude, output latitude, output radius,
		input ready);
	modport sink (input valid, input longitude, input latitude, input radius,
		output ready);
endinterface

// ===== rtl/core/cartesian_to_spherical_core.sv =====
// Throughput: one point per cycle while the skid slot is empty, set by the fully
// pipelined CORDIC and root chain. Each stage holds one vectoring step; the first
// ROOT_STEPS stages also hold one square-root digit. A one-word skid slot behind the
// output register takes one more word while a word waits.
// Reset clears the valid flags only; no clearing pass.
// ----------------------------------------------------------------------------
// cartesian_to_spherical_core
// Converts a signed cartesian point to longitude, latitude and radius using
// two chained CORDIC vectoring runs and a digit-per-stage square root.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_core
	import c2s_pkg::*;
#(
	parameter int CORDIC_STAGES = 32
)
(
	input  logic      clk,
	input  logic      arst_n,
	c2s_in_if.sink    in_ch,
	c2s_out_if.source out_ch
);

	localparam int CHAIN_LEN = 2 * CORDIC_STAGES;

	logic      en;
	c2s_work_t work_chain [CHAIN_LEN+1];
	logic      valid_chain [CHAIN_LEN+1];

	c2s_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_ch    (in_ch),
		.work_s2  (work_chain[0]),
		.valid_s2 (valid_chain[0])
	);

	generate
		for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_stage
			c2s_stage #(
				.STAGE_IDX     (k),
				.CORDIC_STAGES (CORDIC_STAGES)
			) u_stage (
				.clk        (clk),
				.arst_n     (arst_n),
				.en         (en),
				.prev_work  (work_chain[k]),
				.prev_valid (valid_chain[k]),
				.work_sn    (work_chain[k+1]),
				.valid_sn   (valid_chain[k+1])
			);
		end
	endgenerate

	c2s_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.fin_work  (work_chain[CHAIN_LEN]),
		.fin_valid (valid_chain[CHAIN_LEN]),
		.en        (en),
		.out_ch    (out_ch)
	);

endmodule

// ===== rtl/core/c2s_prep.sv =====
// ----------------------------------------------------------------------------
// c2s_prep
// Front end: classify the point, set up the planar vector, form the squares
// and the gain-scaled z, then sum the squares and align z.
// ----------------------------------------------------------------------------
module c2s_prep
	import c2s_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	c2s_in_if.sink    in_ch,
	output c2s_work_t work_s2,
	output logic      valid_s2
);

	logic signed [COORD_W-1:0] sx;
	logic signed [COORD_W-1:0] sy;
	logic signed [COORD_W-1:0] sz;
	logic signed [VEC_W-1:0]   vx;
	logic signed [VEC_W-1:0]   vy;
	logic signed [VEC_W-1:0]   prod_x;
	logic signed [VEC_W-1:0]   prod_y;
	logic signed [VEC_W-1:0]   prod_z;
	logic signed [VEC_W-1:0]   prod_g;
	c2s_flags_t                flags;

	logic                      valid_s1;
	logic signed [VEC_W-1:0]   cx_s1;
	logic signed [VEC_W-1:0]   cy_s1;
	logic [ANGLE_W-1:0]        acc_s1;
	logic [VEC_W-1:0]          sqx_s1;
	logic [VEC_W-1:0]          sqy_s1;
	logic [VEC_W-1:0]          sqz_s1;
	logic signed [VEC_W-1:0]   zg_s1;
	c2s_flags_t                flags_s1;

	assign in_ch.ready = en;

	assign sx = in_ch.x_coord;
	assign sy = in_ch.y_coord;
	assign sz = in_ch.z_coord;

	assign vx = $signed({{(VEC_W-COORD_W-GUARD_BITS){sx[COORD_W-1]}}, sx,
		{GUARD_BITS{1'b0}}});
	assign vy = $signed({{(VEC_W-COORD_W-GUARD_BITS){sy[COORD_W-1]}}, sy,
		{GUARD_BITS{1'b0}}});

	assign prod_x = sx * sx;
	assign prod_y = sy * sy;
	assign prod_z = sz * sz;
	assign prod_g = sz * GAIN_Q30;

	always_comb begin
		flags.x_neg  = sx[COORD_W-1];
		flags.x_zero = (sx == '0);
		flags.y_zero = (sy == '0);
		flags.y_pos  = !sy[COORD_W-1] && (sy != '0);
		flags.z_pos  = !sz[COORD_W-1] && (sz != '0);
		flags.z_neg  = sz[COORD_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_ch.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1    <= flags.x_neg ? -vx : vx;
			cy_s1    <= flags.x_neg ? -vy : vy;
			acc_s1   <= flags.x_neg ? ANGLE_PI : ANGLE_ZERO;
			sqx_s1   <= $unsigned(prod_x);
			sqy_s1   <= $unsigned(prod_y);
			sqz_s1   <= $unsigned(prod_z);
			zg_s1    <= prod_g;
			flags_s1 <= flags;

			work_s2.cx      <= cx_s1;
			work_s2.cy      <= cy_s1;
			work_s2.lz      <= zg_s1 >>> (30 - GUARD_BITS);
			work_s2.lon_acc <= acc_s1;
			work_s2.lat_acc <= ANGLE_ZERO;
			work_s2.rem     <= sqx_s1 + sqy_s1 + sqz_s1;
			work_s2.root    <= '0;
			work_s2.flags   <= flags_s1;
		end
	end

endmodule

// ===== rtl/core/c2s_stage.sv =====
// ----------------------------------------------------------------------------
// c2s_stage
// One pipeline stage: a CORDIC vectoring step (longitude for the first half
// of the chain, latitude for the second) and, below ROOT_STEPS, a root digit.
// ----------------------------------------------------------------------------
module c2s_stage
	import c2s_pkg::*;
#(
	parameter int STAGE_IDX     = 0,
	parameter int CORDIC_STAGES = 32
)
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  c2s_work_t prev_work,
	input  logic      prev_valid,
	output c2s_work_t work_sn,
	output logic      valid_sn
);

	localparam int                 ITER = (STAGE_IDX < CORDIC_STAGES) ?
		STAGE_IDX : STAGE_IDX - CORDIC_STAGES;
	localparam logic [ANGLE_W-1:0] STEP = atan_angle(ITER);

	c2s_work_t               cordic_d;
	c2s_work_t               next_d;
	logic signed [VEC_W-1:0] x_in;
	logic signed [VEC_W-1:0] y_in;
	logic signed [VEC_W-1:0] dx;
	logic signed [VEC_W-1:0] dy;

	assign x_in = prev_work.cx;
	assign y_in = (STAGE_IDX < CORDIC_STAGES) ? prev_work.cy : prev_work.lz;
	assign dx   = y_in >>> ITER;
	assign dy   = x_in >>> ITER;

	generate
		if (STAGE_IDX < CORDIC_STAGES) begin : g_lon
			always_comb begin
				cordic_d = prev_work;
				if (!y_in[VEC_W-1]) begin
					cordic_d.cx      = x_in + dx;
					cordic_d.cy      = y_in - dy;
					cordic_d.lon_acc = prev_work.lon_acc + STEP;
				end else begin
					cordic_d.cx      = x_in - dx;
					cordic_d.cy      = y_in + dy;
					cordic_d.lon_acc = prev_work.lon_acc - STEP;
				end
			end
		end else begin : g_lat
			always_comb begin
				cordic_d = prev_work;
				if (!y_in[VEC_W-1]) begin
					cordic_d.cx      = x_in + dx;
					cordic_d.lz      = y_in - dy;
					cordic_d.lat_acc = prev_work.lat_acc + STEP;
				end else begin
					cordic_d.cx      = x_in - dx;
					cordic_d.lz      = y_in + dy;
					cordic_d.lat_acc = prev_work.lat_acc - STEP;
				end
			end
		end

		if (STAGE_IDX < ROOT_STEPS) begin : g_root
			localparam logic [VEC_W-1:0] ROOT_BIT = 64'd1 << (62 - 2 * STAGE_IDX);
			logic [VEC_W-1:0] trial;

			assign trial = prev_work.root + ROOT_BIT;

			always_comb begin
				next_d = cordic_d;
				if (prev_work.rem >= trial) begin
					next_d.rem  = prev_work.rem - trial;
					next_d.root = (prev_work.root >> 1) + ROOT_BIT;
				end else begin
					next_d.root = prev_work.root >> 1;
				end
			end
		end else begin : g_hold
			assign next_d = cordic_d;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (en) begin
			valid_sn <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_sn <= next_d;
		end
	end

endmodule

// ===== rtl/core/c2s_post.sv =====
// ----------------------------------------------------------------------------
// c2s_post
// Back end: axis and origin cases, latitude clamp, radius rounding, then an
// output register with a skid slot that takes one more word while a word
// waits, before the pipeline stalls.
// ----------------------------------------------------------------------------
module c2s_post
	import c2s_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  c2s_work_t fin_work,
	input  logic      fin_valid,
	output logic      en,
	c2s_out_if.source out_ch
);

	c2s_result_t               res;
	c2s_flags_t                fl;
	logic signed [ANGLE_W-1:0] lat_raw;
	logic [RADIUS_W:0]         rad_full;

	c2s_result_t               out_q;
	c2s_result_t               skid_q;
	logic                      out_valid_q;
	logic                      skid_valid_q;

	assign fl      = fin_work.flags;
	assign lat_raw = fin_work.lat_acc;
	assign rad_full = {1'b0, fin_work.root[RADIUS_W-1:0]}
		+ (RADIUS_W+1)'(fin_work.rem > fin_work.root);

	always_comb begin
		if (fl.y_zero) begin
			res.longitude = fl.x_neg ? ANGLE_PI : ANGLE_ZERO;
		end else if (fl.x_zero) begin
			res.longitude = fl.y_pos ? ANGLE_HALF_PI : ANGLE_NEG_HALF_PI;
		end else begin
			res.longitude = fin_work.lon_acc;
		end

		if (fl.x_zero && fl.y_zero) begin
			if (fl.z_pos) begin
				res.latitude = ANGLE_HALF_PI;
			end else if (fl.z_neg) begin
				res.latitude = ANGLE_NEG_HALF_PI;
			end else begin
				res.latitude = ANGLE_ZERO;
			end
		end else if (!fl.z_pos && !fl.z_neg) begin
			res.latitude = ANGLE_ZERO;
		end else if (lat_raw > $signed(ANGLE_HALF_PI)) begin
			res.latitude = ANGLE_HALF_PI;
		end else if (lat_raw < $signed(ANGLE_NEG_HALF_PI)) begin
			res.latitude = ANGLE_NEG_HALF_PI;
		end else begin
			res.latitude = lat_raw;
		end

		res.radius = rad_full[RADIUS_W] ? '1 : rad_full[RADIUS_W-1:0];
	end

	assign en = !skid_valid_q;

	// hold the word in the skid slot while the output is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_ch.ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (fin_valid) begin
			if (!out_valid_q || out_ch.ready) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_ch.ready) begin
				out_q <= skid_q;
			end
		end else if (fin_valid) begin
			if (!out_valid_q || out_ch.ready) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.longitude = out_q.longitude;
	assign out_ch.latitude  = out_q.latitude;
	assign out_ch.radius    = out_q.radius;

endmodule
